### rtl/m4md_pkg.sv
`default_nettype none
package m4md_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = ELEM_WIDTH / 2;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;
    localparam int DET_WIDTH  = 4 * ELEM_WIDTH + 5;
    localparam int ADDR_WIDTH = 4;
    localparam int DEPTH      = 16;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]        element_index;
        logic signed [ELEM_WIDTH-1:0] a_value;
        logic signed [ELEM_WIDTH-1:0] b_value;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] product_value;
        logic [ADDR_WIDTH-1:0]        product_position;
        logic                         product_clipped;
        logic signed [ELEM_WIDTH-1:0] determinant_value;
        logic                         determinant_clipped;
        logic                         final_flag;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET,
        ST_DET_WAIT,
        ST_PROD,
        ST_PROD_WAIT,
        ST_EMIT
    } t_state;

    // sequencer read addresses toward the element memories
    typedef struct packed {
        logic [ADDR_WIDTH-1:0] a_addr;
        logic [ADDR_WIDTH-1:0] b_addr;
    } t_ctl;

endpackage
`default_nettype wire

### rtl/matrix4_multiply_determinant.sv
`default_nettype none
// load transactions (index 0 to 14) are accepted one per cycle while busy is low and give no result
// a start transaction (index 15) first runs the determinant work; then the 16 results
// are made in order, each from four reads of the two element memories, a wait state for
// the last read data and an emit; busy falls in the cycle of the last result, and the
// receiver cannot stall results
// reset (synchronous, active low) clears control, then a pass over all 16 addresses zeroes both memories
module matrix4_multiply_determinant (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire m4md_pkg::t_in_item       i_item,
    output logic                          o_strobe,
    output m4md_pkg::t_out_item           o_item
);
    localparam int EW = m4md_pkg::ELEM_WIDTH;
    localparam int AW = m4md_pkg::ACC_WIDTH;

    m4md_pkg::t_state r_state, n_state;
    logic [4:0] r_clr;
    logic [3:0] r_pos;
    logic [1:0] r_k;
    logic       r_kvalid;
    logic signed [AW-1:0] r_acc;
    logic signed [EW-1:0] r_detv;
    logic                 r_detc;
    m4md_pkg::t_ctl ctl;

    logic accept;
    logic clearing;
    assign clearing = !r_clr[4];
    assign accept   = start && !busy;

    logic we;
    logic [3:0] waddr;
    logic [EW-1:0] wa, wb, ra, rb;
    assign we    = accept || clearing;
    assign waddr = clearing ? r_clr[3:0] : i_item.element_index;
    assign wa    = clearing ? '0 : i_item.a_value;
    assign wb    = clearing ? '0 : i_item.b_value;

    m4md_store u_a (.i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wa),
                    .i_raddr(ctl.a_addr), .o_rdata(ra));
    m4md_store u_b (.i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wb),
                    .i_raddr(ctl.b_addr), .o_rdata(rb));

    logic det_done;
    logic signed [EW-1:0] detv;
    logic detc;
    m4md_det u_det (.i_clk, .i_rst_n, .i_load(we), .i_load_idx(waddr), .i_load_val(wa),
                    .i_start(accept && i_item.element_index == 4'd15),
                    .o_done(det_done), .o_det(detv), .o_clip(detc));

    always_comb begin
        ctl.a_addr = {r_pos[3:2], r_k};
        ctl.b_addr = {r_k, r_pos[1:0]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            m4md_pkg::ST_IDLE:
                if (accept && i_item.element_index == 4'd15) n_state = m4md_pkg::ST_DET;
            m4md_pkg::ST_DET:       if (det_done) n_state = m4md_pkg::ST_PROD;
            m4md_pkg::ST_PROD:      if (r_k == 2'd3) n_state = m4md_pkg::ST_PROD_WAIT;
            m4md_pkg::ST_PROD_WAIT: n_state = m4md_pkg::ST_EMIT;
            m4md_pkg::ST_EMIT:
                n_state = (r_pos == 4'd15) ? m4md_pkg::ST_IDLE : m4md_pkg::ST_PROD;
            default: n_state = m4md_pkg::ST_IDLE;
        endcase
    end

    assign busy = clearing || (r_state != m4md_pkg::ST_IDLE);

    logic signed [m4md_pkg::PROD_WIDTH-1:0] p;
    assign p = $signed(ra) * $signed(rb);

    logic signed [AW-1:0] sh;
    logic signed [EW-1:0] pv;
    logic pc;
    always_comb begin
        sh = r_acc >>> m4md_pkg::FRAC_BITS;
        if (sh > AW'($signed({1'b0, {(EW-1){1'b1}}}))) begin
            pv = {1'b0, {(EW-1){1'b1}}}; pc = 1'b1;
        end else if (sh < -(AW'(1) <<< (EW-1))) begin
            pv = {1'b1, {(EW-1){1'b0}}}; pc = 1'b1;
        end else begin
            pv = sh[EW-1:0]; pc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= m4md_pkg::ST_IDLE;
            r_clr    <= '0;
            r_pos    <= '0;
            r_k      <= '0;
            r_kvalid <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == m4md_pkg::ST_EMIT);
            if (clearing) r_clr <= r_clr + 5'd1;
            // read data is registered and arrives in the cycle after the address
            r_kvalid <= (r_state == m4md_pkg::ST_PROD);
            if (det_done) begin
                r_detv <= detv; r_detc <= detc; r_pos <= '0; r_k <= '0; r_acc <= '0;
            end
            if (r_state == m4md_pkg::ST_PROD) r_k <= r_k + 2'd1;
            if (r_kvalid) r_acc <= r_acc + AW'(p);
            if (r_state == m4md_pkg::ST_EMIT) begin
                o_item.product_value       <= pv;
                o_item.product_position    <= r_pos;
                o_item.product_clipped     <= pc;
                o_item.final_flag          <= (r_pos == 4'd15);
                o_item.determinant_value   <= (r_pos == 4'd15) ? r_detv : '0;
                o_item.determinant_clipped <= (r_pos == 4'd15) && r_detc;
                r_pos <= r_pos + 4'd1;
                r_acc <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/m4md_store.sv
`default_nettype none
module m4md_store (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [m4md_pkg::ADDR_WIDTH-1:0]     i_waddr,
    input  wire logic [m4md_pkg::ELEM_WIDTH-1:0]     i_wdata,
    input  wire logic [m4md_pkg::ADDR_WIDTH-1:0]     i_raddr,
    output logic [m4md_pkg::ELEM_WIDTH-1:0]          o_rdata
);
    logic [m4md_pkg::ELEM_WIDTH-1:0] r_mem [m4md_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/m4md_det.sv
`default_nettype none
// determinant of a 4x4 held in a register bank, one narrow multiply per cycle
module m4md_det (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_load,
    input  wire logic [m4md_pkg::ADDR_WIDTH-1:0]     i_load_idx,
    input  wire logic [m4md_pkg::ELEM_WIDTH-1:0]     i_load_val,
    input  wire logic                                i_start,
    output logic                                     o_done,
    output logic signed [m4md_pkg::ELEM_WIDTH-1:0]   o_det,
    output logic                                     o_clip
);
    localparam int EW = m4md_pkg::ELEM_WIDTH;
    localparam int DW = m4md_pkg::DET_WIDTH;
    localparam int SH = 3 * m4md_pkg::FRAC_BITS;

    logic signed [EW-1:0] r_e [m4md_pkg::DEPTH];
    logic [6:0]           r_step;
    logic [1:0]           r_limb;
    logic                 r_run;
    logic signed [DW-1:0] r_c2, r_m3, r_det;

    // schedule: for each row-0 column j, for each of three minor terms,
    // a 2x2 cross (two multiplies) and a scale by row 1; after the three terms, a scale by row 0
    logic [1:0] j_col, t_term;
    logic [2:0] sub;
    logic [1:0] c0, c1, c2, ca, cb, cm;
    logic [1:0] cols [3];

    logic signed [DW-1:0] wide_y;
    logic [EW-1:0]        limb;
    logic signed [EW:0]   y_limb;
    logic signed [EW-1:0] mul_x;
    logic signed [EW:0]   mul_y;
    logic signed [2*EW:0] mprod;
    logic signed [DW-1:0] part;
    logic                 last_limb;
    logic signed [DW-1:0] shifted;

    always_comb begin
        j_col  = r_step[6:5];
        t_term = r_step[4:3];
        sub    = r_step[2:0];
        cols[0] = (j_col == 2'd0) ? 2'd1 : 2'd0;
        cols[1] = (j_col <= 2'd1) ? 2'd2 : 2'd1;
        cols[2] = (j_col <= 2'd2) ? 2'd3 : 2'd2;
        c0 = cols[0]; c1 = cols[1]; c2 = cols[2];
        case (t_term)
            2'd0:    begin cm = c0; ca = c1; cb = c2; end
            2'd1:    begin cm = c1; ca = c0; cb = c2; end
            default: begin cm = c2; ca = c0; cb = c1; end
        endcase
    end

    // scaling steps take the wide operand one limb per cycle, lowest first;
    // only the top limb carries the sign
    always_comb begin
        wide_y = (sub == 3'd2) ? r_c2 : r_m3;
        limb   = wide_y[r_limb * EW +: EW];
        y_limb = (r_limb == 2'd3) ? $signed({limb[EW-1], limb}) : $signed({1'b0, limb});
        case (sub)
            3'd0: begin
                mul_x = r_e[{2'd2, ca}];
                mul_y = (EW+1)'(r_e[{2'd3, cb}]);
            end
            3'd1: begin
                mul_x = r_e[{2'd2, cb}];
                mul_y = (EW+1)'(r_e[{2'd3, ca}]);
            end
            3'd2: begin
                mul_x = r_e[{2'd1, cm}];
                mul_y = y_limb;
            end
            default: begin
                mul_x = r_e[{2'd0, j_col}];
                mul_y = y_limb;
            end
        endcase
    end

    assign mprod     = mul_x * mul_y;
    assign part      = DW'(mprod) <<< (r_limb * EW);
    assign last_limb = (sub < 3'd2) || (r_limb == 2'd3);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_e[i_load_idx] <= i_load_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            r_limb <= '0;
            o_done <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1; r_step <= '0; r_limb <= '0; r_det <= '0; r_m3 <= '0;
            o_done <= 1'b0;
        end else if (r_run) begin
            o_done <= (sub == 3'd3) && last_limb && (j_col == 2'd3);
            case (sub)
                3'd0: r_c2 <= DW'(mprod);
                3'd1: r_c2 <= r_c2 - DW'(mprod);
                3'd2: r_m3 <= (t_term == 2'd1) ? r_m3 - part : r_m3 + part;
                default: begin
                    r_det <= j_col[0] ? r_det - part : r_det + part;
                    if (last_limb) r_m3 <= '0;
                end
            endcase
            if (!last_limb) begin
                r_limb <= r_limb + 2'd1;
            end else begin
                r_limb <= '0;
                // terms use sub 0..2; after term 2 go to sub 3 for row 0
                if (sub == 3'd2 && t_term != 2'd2) begin
                    r_step <= {j_col, t_term + 2'd1, 3'd0};
                end else if (sub == 3'd2) begin
                    r_step <= {j_col, t_term, 3'd3};
                end else if (sub == 3'd3) begin
                    if (j_col == 2'd3) r_run <= 1'b0;
                    r_step <= {j_col + 2'd1, 2'd0, 3'd0};
                end else begin
                    r_step <= r_step + 7'd1;
                end
            end
        end else begin
            o_done <= 1'b0;
        end
    end

    // rescale and saturate the finished determinant
    always_comb begin
        shifted = r_det >>> SH;
        if (shifted > DW'($signed({1'b0, {(EW-1){1'b1}}}))) begin
            o_det = {1'b0, {(EW-1){1'b1}}}; o_clip = 1'b1;
        end else if (shifted < -(DW'(1) <<< (EW-1))) begin
            o_det = {1'b1, {(EW-1){1'b0}}}; o_clip = 1'b1;
        end else begin
            o_det = shifted[EW-1:0]; o_clip = 1'b0;
        end
    end
endmodule
`default_nettype wire

### test/matrix4_multiply_determinant_test.sv
`default_nettype none
module matrix4_multiply_determinant_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [m4md_pkg::ELEM_WIDTH-1:0] MAX_V = 32'sh7fffffff;
    localparam logic signed [m4md_pkg::ELEM_WIDTH-1:0] MIN_V = 32'sh80000000;
    localparam int RANDOM_ITEMS = 410;

    typedef logic signed [199:0] t_wide;

    typedef struct {
        logic [m4md_pkg::ADDR_WIDTH-1:0]        idx;
        logic signed [m4md_pkg::ELEM_WIDTH-1:0] a;
        logic signed [m4md_pkg::ELEM_WIDTH-1:0] b;
        bit                                     known;
        logic signed [m4md_pkg::ELEM_WIDTH-1:0] det;
        logic                                   det_clip;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    m4md_pkg::t_in_item  i_item = '0;
    logic                o_strobe;
    m4md_pkg::t_out_item o_item;

    logic signed [m4md_pkg::ELEM_WIDTH-1:0] left_mat [16];
    logic signed [m4md_pkg::ELEM_WIDTH-1:0] right_mat [16];
    m4md_pkg::t_out_item pending_products [$];
    int mismatches = 0;
    int sent = 0;
    int idle_pct = 0;

    matrix4_multiply_determinant dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_item   (o_item)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #3ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void saturate(input t_wide v,
                                     output logic signed [m4md_pkg::ELEM_WIDTH-1:0] r,
                                     output logic clip);
        t_wide hi, lo;
        hi = MAX_V;
        lo = MIN_V;
        clip = 1'b1;
        if (v > hi) r = MAX_V;
        else if (v < lo) r = MIN_V;
        else begin
            r = v[m4md_pkg::ELEM_WIDTH-1:0];
            clip = 1'b0;
        end
    endfunction

    function automatic t_wide la(input int i);
        t_wide w;
        w = left_mat[i];
        return w;
    endfunction

    function automatic t_wide minor3(input int c0, input int c1, input int c2);
        t_wide t0, t1, t2;
        t0 = la(4+c0) * (la(8+c1) * la(12+c2) - la(8+c2) * la(12+c1));
        t1 = la(4+c1) * (la(8+c0) * la(12+c2) - la(8+c2) * la(12+c0));
        t2 = la(4+c2) * (la(8+c0) * la(12+c1) - la(8+c1) * la(12+c0));
        return t0 - t1 + t2;
    endfunction

    // store the pair; on the starting index queue the 16 product elements
    task automatic predict_products(input t_row r);
        t_wide det, acc, wb;
        logic signed [m4md_pkg::ELEM_WIDTH-1:0] dv, pv;
        logic dc, pc;
        m4md_pkg::t_out_item e;
        left_mat[r.idx] = r.a;
        right_mat[r.idx] = r.b;
        if (r.idx != 4'd15) return;
        det = la(0) * minor3(1, 2, 3) - la(1) * minor3(0, 2, 3)
            + la(2) * minor3(0, 1, 3) - la(3) * minor3(0, 1, 2);
        saturate(det >>> (3 * m4md_pkg::FRAC_BITS), dv, dc);
        if (r.known) begin
            dv = r.det;
            dc = r.det_clip;
        end
        for (int p = 0; p < 16; p++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                wb = right_mat[k*4 + p%4];
                acc = acc + la((p/4)*4 + k) * wb;
            end
            saturate(acc >>> m4md_pkg::FRAC_BITS, pv, pc);
            e.product_value = pv;
            e.product_position = p[3:0];
            e.product_clipped = pc;
            e.determinant_value = (p == 15) ? dv : '0;
            e.determinant_clipped = (p == 15) ? dc : 1'b0;
            e.final_flag = (p == 15);
            pending_products.push_back(e);
        end
    endtask

    task automatic send(input t_row r);
        if ($urandom_range(99) < idle_pct) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= '{element_index: r.idx, a_value: r.a, b_value: r.b};
        do @(posedge i_clk); while (busy);
        predict_products(r);
        sent++;
    endtask

    function automatic logic signed [m4md_pkg::ELEM_WIDTH-1:0] pick_value(input int mode);
        case (mode)
            0: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            1: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return MAX_V;
                    1: return MIN_V;
                    2: return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_products.size() == 0) begin
                report("unexpected product transaction", o_item.product_position, 0);
            end else begin
                m4md_pkg::t_out_item e;
                e = pending_products.pop_front();
                if (o_item.product_value !== e.product_value)
                    report("product_value", o_item.product_value, e.product_value);
                if (o_item.product_position !== e.product_position)
                    report("product_position", o_item.product_position, e.product_position);
                if (o_item.product_clipped !== e.product_clipped)
                    report("product_clipped", o_item.product_clipped, e.product_clipped);
                if (o_item.determinant_value !== e.determinant_value)
                    report("determinant_value", o_item.determinant_value, e.determinant_value);
                if (o_item.determinant_clipped !== e.determinant_clipped)
                    report("determinant_clipped", o_item.determinant_clipped,
                           e.determinant_clipped);
                if (o_item.final_flag !== e.final_flag)
                    report("final_flag", o_item.final_flag, e.final_flag);
            end
        end
    end

    initial begin
        t_row directed [14];
        int order [15];
        int mode, tmp, j;
        t_row r;

        directed = '{
            '{4'd15, 32'sh0, 32'sh0, 1, 32'sh0, 1'b0},
            '{4'd0, 32'sh20000, 32'sh10000, 0, 0, 0},
            '{4'd5, 32'sh20000, 32'sh30000, 0, 0, 0},
            '{4'd10, 32'sh20000, -32'sh10000, 0, 0, 0},
            // 2.0 on the diagonal gives 16.0
            '{4'd15, 32'sh20000, 32'sh8000, 1, 32'sh100000, 1'b0},
            '{4'd0, MAX_V, MAX_V, 0, 0, 0},
            '{4'd5, MAX_V, MAX_V, 0, 0, 0},
            '{4'd10, MAX_V, MAX_V, 0, 0, 0},
            '{4'd15, MAX_V, MAX_V, 1, MAX_V, 1'b1},
            '{4'd15, MIN_V, MIN_V, 1, MIN_V, 1'b1},
            '{4'd1, -32'sh1, MAX_V, 0, 0, 0},
            '{4'd3, MIN_V, 32'sh1, 0, 0, 0},
            '{4'd12, 32'shffffffff, MIN_V, 0, 0, 0},
            '{4'd15, 32'sh10000, 32'shffff0000, 0, 0, 0}
        };
        for (int i = 0; i < 16; i++) begin
            left_mat[i] = '0;
            right_mat[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send(directed[i]);
        sent = 0;

        while (sent < RANDOM_ITEMS) begin
            idle_pct = (sent < RANDOM_ITEMS/3) ? 20 : (sent < 2*RANDOM_ITEMS/3) ? 78 : 0;
            mode = $urandom_range(0, 2);
            r.known = 0;
            if ($urandom_range(0, 9) < 8) begin
                // complete load in shuffled order, started by the last index
                for (int i = 0; i < 15; i++) order[i] = i;
                for (int i = 14; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < 16; i++) begin
                    r.idx = (i == 15) ? 4'd15 : order[i][3:0];
                    r.a = pick_value(mode);
                    r.b = pick_value(mode);
                    send(r);
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    r.idx = 4'($urandom_range(0, 15));
                    r.a = pick_value(mode);
                    r.b = pick_value(mode);
                    send(r);
                end
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_products.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
